>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define PLIRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define PLIRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/plirs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plirs_pkg;

  localparam int CAPACITY  = 8 << 2;
  localparam int ELEM_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = IDX_W + 1;

  // Request codes
  localparam logic [2:0] REQ_APPEND     = 3'd0;
  localparam logic [2:0] REQ_REMOVE_AT  = 3'd1;
  localparam logic [2:0] REQ_REMOVE_VAL = 3'd2;
  localparam logic [2:0] REQ_CONTAINS   = 3'd3;
  localparam logic [2:0] REQ_INDEX_OF   = 3'd4;
  localparam logic [2:0] REQ_READ       = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'h2;
  localparam logic [2:0] ST_MISS  = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [ELEM_BITS-1:0] wdata;
    logic                 re;
    logic [IDX_W-1:0]     raddr;
  } ram_req_t;

endpackage

`default_nettype wire

>>> sv/plirs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module plirs_ram (
  input  wire logic                           clk,
  input  wire plirs_pkg::ram_req_t            req,
  output logic [plirs_pkg::ELEM_BITS-1:0]     rdata
);
  import plirs_pkg::*;

  logic [ELEM_BITS-1:0] mem [CAPACITY];
  logic [ELEM_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> sv/packed_list_insert_remove_search_core.sv
// Channel   Ports                                              Direction
// -------   -------------------------------------------------  ---------
// in        in_valid, in_stall, in_req_type, in_element,        in
//           in_position
// out       out_valid, out_stall, out_status, out_read_element, out
//           out_found_index, out_count
//
// Append, range errors and zero-handle requests go straight to the final state;
// read passes through a read state first. Search walks the list one entry per cycle.
// Remove shifts one entry per cycle through the separate read and write ports
// of the entry RAM, moving each later entry down one slot.
// Synchronous active-low reset empties the list; stored entries are not cleared.
// A stalled result holds in the output register; the next transaction waits in
// the final state until that register frees up.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module packed_list_insert_remove_search_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [2:0]                      in_req_type,
  input  wire logic [plirs_pkg::ELEM_BITS-1:0] in_element,
  input  wire logic [plirs_pkg::IDX_W-1:0]     in_position,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [2:0]                           out_status,
  output logic [plirs_pkg::ELEM_BITS-1:0]      out_read_element,
  output logic [plirs_pkg::IDX_W-1:0]          out_found_index,
  output logic [plirs_pkg::CNT_W-1:0]          out_count
);
  import plirs_pkg::*;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [2:0]           req_r, req_nxt;
  logic [ELEM_BITS-1:0] elem_r, elem_nxt;
  logic [2:0]           res_status_r, res_status_nxt;
  logic [ELEM_BITS-1:0] res_rd_r, res_rd_nxt;
  logic [IDX_W-1:0]     res_fidx_r, res_fidx_nxt;

  logic [2:0]           out_status_r, out_status_nxt;
  logic [ELEM_BITS-1:0] out_rd_r, out_rd_nxt;
  logic [IDX_W-1:0]     out_fidx_r, out_fidx_nxt;
  logic [CNT_W-1:0]     out_count_r, out_count_nxt;

  ram_req_t             ram_req;
  logic [ELEM_BITS-1:0] ram_rdata;

  logic [CNT_W-1:0]     idx_p1, idx_p2, pos_ext;

  plirs_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign idx_p1  = {1'b0, idx_r} + CNT_W'(1);
  assign idx_p2  = {1'b0, idx_r} + CNT_W'(2);
  assign pos_ext = {1'b0, in_position};

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    req_nxt        = req_r;
    elem_nxt       = elem_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    res_fidx_nxt   = res_fidx_r;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_fidx_nxt   = out_fidx_r;
    out_count_nxt  = out_count_r;
    ram_req        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_req_type;
          elem_nxt       = in_element;
          res_status_nxt = ST_OK;
          res_rd_nxt     = '0;
          res_fidx_nxt   = '0;
          state_nxt      = S_DONE;
          case (in_req_type) inside
            REQ_APPEND: begin
              if (in_element == '0) begin
                res_status_nxt = ST_ZERO;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = count_r[IDX_W-1:0];
                ram_req.wdata = in_element;
                count_nxt     = count_r + CNT_W'(1);
              end
            end
            REQ_REMOVE_AT: begin
              if (pos_ext >= count_r) begin
                res_status_nxt = ST_RANGE;
              end else if ((pos_ext + CNT_W'(1)) < count_r) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = in_position + IDX_W'(1);
                idx_nxt       = in_position;
                state_nxt     = S_SHIFT;
              end else begin
                // last entry: nothing to shift
                count_nxt = count_r - CNT_W'(1);
              end
            end
            REQ_REMOVE_VAL, REQ_CONTAINS, REQ_INDEX_OF: begin
              if (in_element == '0) begin
                res_status_nxt = ST_ZERO;
              end else if (count_r == '0) begin
                res_status_nxt = ST_MISS;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = '0;
                idx_nxt       = '0;
                state_nxt     = S_SCAN;
              end
            end
            REQ_READ: begin
              if (pos_ext >= count_r) begin
                res_status_nxt = ST_RANGE;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = in_position;
                state_nxt     = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // prefetch the next entry while comparing the current one
        ram_req.re    = 1'b1;
        ram_req.raddr = idx_p1[IDX_W-1:0];
        if (ram_rdata == elem_r) begin
          state_nxt = S_DONE;
          case (req_r)
            REQ_INDEX_OF: begin
              res_fidx_nxt = idx_r;
            end
            REQ_REMOVE_VAL: begin
              if (idx_p1 < count_r) begin
                state_nxt = S_SHIFT;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end else if (idx_p1 >= count_r) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_p1[IDX_W-1:0];
        end
      end

      S_SHIFT: begin
        // move entry idx+1 down to idx; read idx+2, if in the list, in the same cycle
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = ram_rdata;
        if (idx_p2 < count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_p2[IDX_W-1:0];
          idx_nxt       = idx_p1[IDX_W-1:0];
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_READ: begin
        res_rd_nxt = ram_rdata;
        state_nxt  = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rd_nxt     = res_rd_r;
          out_fidx_nxt   = res_fidx_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    elem_r       <= elem_nxt;
    res_status_r <= res_status_nxt;
    res_rd_r     <= res_rd_nxt;
    res_fidx_r   <= res_fidx_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_fidx_r   <= out_fidx_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_read_element = out_rd_r;
  assign out_found_index  = out_fidx_r;
  assign out_count        = out_count_r;

  `PLIRS_ASSERT(a_count_cap, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `PLIRS_ASSERT(a_scan_in_list, (state_r == S_SCAN) |-> ({1'b0, idx_r} < count_r),
    "scan index past end of list")
  `PLIRS_ASSERT(a_shift_src, (state_r == S_SHIFT) |-> (idx_p1 < count_r),
    "shift source past end of list")
  `PLIRS_ASSERT(a_count_step, ($past(rst_n) && !$stable(count_r)) |->
    ((count_r == $past(count_r) + CNT_W'(1)) || (count_r + CNT_W'(1) == $past(count_r))),
    "entry count moved by more than one")
  `PLIRS_ASSERT(a_out_from_done, ($past(rst_n) && $rose(out_valid_r)) |->
    ($past(state_r) == S_DONE), "result presented outside the final state")

endmodule

`default_nettype wire

>>> tb/sv/packed_list_insert_remove_search_core_tb.sv
`timescale 1ns / 1ps

module packed_list_insert_remove_search_core_tb;
  import plirs_pkg::*;

  // Unused request codes; the block answers them with an OK status
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [2:0]           status;
    logic [ELEM_BITS-1:0] read_element;
    logic [IDX_W-1:0]     found_index;
    logic [CNT_W-1:0]     count;
  } list_result_t;

  typedef struct {
    logic [2:0]           req;
    logic [ELEM_BITS-1:0] elem;
    logic [IDX_W-1:0]     pos;
    bit                   typed;
    list_result_t         want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_req_type = REQ_READ;
  logic [ELEM_BITS-1:0] in_element  = '0;
  logic [IDX_W-1:0]     in_position = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [2:0]           out_status;
  logic [ELEM_BITS-1:0] out_read_element;
  logic [IDX_W-1:0]     out_found_index;
  logic [CNT_W-1:0]     out_count;

  // Shadow copy of the list
  logic [ELEM_BITS-1:0] list_mem [CAPACITY];
  int                   list_len;

  list_result_t expected_results [$];
  stim_row_t    directed_rows [$];
  int           fail_cnt  = 0;
  int           cycle_cnt = 0;
  bit           calm      = 1'b0;
  bit           fill_mode = 1'b1;

  packed_list_insert_remove_search_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_element      (in_element),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_element(out_read_element),
    .out_found_index (out_found_index),
    .out_count       (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void remove_slot(input int slot);
    for (int k = slot; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
    list_mem[list_len - 1] = '0;
    list_len--;
  endfunction

  function automatic list_result_t apply_to_list(input logic [2:0] req,
                                                 input logic [ELEM_BITS-1:0] elem,
                                                 input logic [IDX_W-1:0] pos);
    list_result_t r;
    int           hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    case (req)
      REQ_APPEND: begin
        if (elem == '0) r.status = ST_ZERO;
        else if (list_len >= CAPACITY) r.status = ST_FULL;
        else begin
          list_mem[list_len] = elem;
          list_len++;
        end
      end
      REQ_REMOVE_AT: begin
        if (int'(pos) >= list_len) r.status = ST_RANGE;
        else remove_slot(int'(pos));
      end
      REQ_REMOVE_VAL, REQ_CONTAINS, REQ_INDEX_OF: begin
        if (elem == '0) r.status = ST_ZERO;
        else begin
          for (int k = 0; k < list_len; k++) begin
            if (hit < 0 && list_mem[k] == elem) hit = k;
          end
          if (hit < 0) r.status = ST_MISS;
          else if (req == REQ_REMOVE_VAL) remove_slot(hit);
          else if (req == REQ_INDEX_OF) r.found_index = IDX_W'(hit);
        end
      end
      REQ_READ: begin
        if (int'(pos) >= list_len) r.status = ST_RANGE;
        else r.read_element = list_mem[pos];
      end
      default: ;
    endcase
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic stim_row_t row(input logic [2:0] req, input logic [ELEM_BITS-1:0] elem,
                                    input logic [IDX_W-1:0] pos, input bit typed,
                                    input logic [2:0] status, input int count);
    stim_row_t s;
    s.req   = req;
    s.elem  = elem;
    s.pos   = pos;
    s.typed = typed;
    s.want  = '{status: status, read_element: '0, found_index: '0, count: CNT_W'(count)};
    return s;
  endfunction

  task automatic send_request(input stim_row_t s);
    int           gap;
    list_result_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= s.req;
    in_element  <= s.elem;
    in_position <= s.pos;
    do @(posedge clk); while (in_stall);
    // Transaction accepted at this edge
    predicted = apply_to_list(s.req, s.elem, s.pos);
    expected_results.push_back(s.typed ? s.want : predicted);
  endtask

  function automatic stim_row_t random_row();
    stim_row_t s;
    int        r;
    s.typed = 1'b0;
    s.want  = '0;
    // Sweep the fill level between empty and full, lingering at both ends
    if (fill_mode && list_len == CAPACITY && $urandom_range(0, 3) == 0) fill_mode = 1'b0;
    if (!fill_mode && list_len == 0 && $urandom_range(0, 3) == 0) fill_mode = 1'b1;
    r = $urandom_range(0, 99);
    if (fill_mode) begin
      if (r < 55) s.req = REQ_APPEND;
      else if (r < 63) s.req = REQ_REMOVE_AT;
      else if (r < 70) s.req = REQ_REMOVE_VAL;
      else if (r < 79) s.req = REQ_CONTAINS;
      else if (r < 88) s.req = REQ_INDEX_OF;
      else if (r < 98) s.req = REQ_READ;
      else s.req = (r == 98) ? REQ_SPARE_A : REQ_SPARE_B;
    end else begin
      if (r < 10) s.req = REQ_APPEND;
      else if (r < 40) s.req = REQ_REMOVE_AT;
      else if (r < 60) s.req = REQ_REMOVE_VAL;
      else if (r < 72) s.req = REQ_CONTAINS;
      else if (r < 84) s.req = REQ_INDEX_OF;
      else if (r < 98) s.req = REQ_READ;
      else s.req = (r == 98) ? REQ_SPARE_A : REQ_SPARE_B;
    end
    r = $urandom_range(0, 99);
    if (r < 5) s.elem = '0;
    else if (r < 35 && list_len > 0) s.elem = list_mem[$urandom_range(0, list_len - 1)];
    else if (r < 75) s.elem = ELEM_BITS'($urandom_range(1, 12));
    else if (r < 90) s.elem = $urandom;
    else if (r < 95) s.elem = ELEM_BITS'(1) << $urandom_range(0, ELEM_BITS - 1);
    else s.elem = ~(ELEM_BITS'(1) << $urandom_range(0, ELEM_BITS - 1));
    if (list_len > 0 && $urandom_range(0, 99) < 80)
      s.pos = IDX_W'($urandom_range(0, list_len - 1));
    else
      s.pos = IDX_W'($urandom_range(0, CAPACITY - 1));
    return s;
  endfunction

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d count %0d", out_status, out_count);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_cnt++;
        end
        if (out_read_element !== want.read_element) begin
          $error("read_element: expected %h, got %h", want.read_element, out_read_element);
          fail_cnt++;
        end
        if (out_found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, out_found_index);
          fail_cnt++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          fail_cnt++;
        end
      end
    end
  end

  // Receiver backpressure
  initial begin
    int hold;
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (pick_gap() + 1) @(posedge clk);
    end
  end

  // Windows with no idling on either side
  initial begin
    forever begin
      repeat ($urandom_range(300, 1500)) @(posedge clk);
      calm <= 1'b1;
      repeat ($urandom_range(50, 300)) @(posedge clk);
      calm <= 1'b0;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int        real_items;
    stim_row_t s;
    for (int k = 0; k < CAPACITY; k++) list_mem[k] = '0;
    list_len = 0;

    directed_rows.push_back(row(REQ_READ,       32'h0,        5'd0,  1, ST_RANGE, 0));
    directed_rows.push_back(row(REQ_REMOVE_AT,  32'h0,        5'd31, 1, ST_RANGE, 0));
    directed_rows.push_back(row(REQ_APPEND,     32'h0,        5'd0,  1, ST_ZERO,  0));
    directed_rows.push_back(row(REQ_REMOVE_VAL, 32'h0,        5'd0,  1, ST_ZERO,  0));
    directed_rows.push_back(row(REQ_CONTAINS,   32'h0,        5'd0,  1, ST_ZERO,  0));
    directed_rows.push_back(row(REQ_INDEX_OF,   32'h0,        5'd0,  1, ST_ZERO,  0));
    directed_rows.push_back(row(REQ_CONTAINS,   32'hFFFFFFFF, 5'd0,  1, ST_MISS,  0));
    directed_rows.push_back(row(REQ_SPARE_A,    32'h5A5A5A5A, 5'd7,  1, ST_OK,    0));
    directed_rows.push_back(row(REQ_SPARE_B,    32'h0,        5'd31, 1, ST_OK,    0));
    directed_rows.push_back(row(REQ_APPEND,     32'hFFFFFFFF, 5'd0,  1, ST_OK,    1));
    directed_rows.push_back(row(REQ_APPEND,     32'h00000001, 5'd0,  1, ST_OK,    2));
    directed_rows.push_back(row(REQ_APPEND,     32'h80000000, 5'd0,  1, ST_OK,    3));
    directed_rows.push_back(row(REQ_APPEND,     32'hFFFFFFFF, 5'd0,  1, ST_OK,    4));
    directed_rows.push_back(row(REQ_READ,       32'h0,        5'd4,  1, ST_RANGE, 4));
    directed_rows.push_back(row(REQ_READ,       32'h0,        5'd31, 1, ST_RANGE, 4));
    directed_rows.push_back(row(REQ_READ,       32'h0,        5'd3,  0, ST_OK,    0));
    directed_rows.push_back(row(REQ_INDEX_OF,   32'h80000000, 5'd0,  0, ST_OK,    0));
    directed_rows.push_back(row(REQ_CONTAINS,   32'h00000001, 5'd0,  0, ST_OK,    0));
    directed_rows.push_back(row(REQ_REMOVE_VAL, 32'hFFFFFFFF, 5'd0,  0, ST_OK,    0));
    directed_rows.push_back(row(REQ_INDEX_OF,   32'hFFFFFFFF, 5'd0,  0, ST_OK,    0));
    directed_rows.push_back(row(REQ_REMOVE_VAL, 32'h12345678, 5'd0,  0, ST_OK,    0));
    directed_rows.push_back(row(REQ_REMOVE_AT,  32'h0,        5'd2,  0, ST_OK,    0));
    directed_rows.push_back(row(REQ_REMOVE_AT,  32'h0,        5'd0,  0, ST_OK,    0));
    directed_rows.push_back(row(REQ_READ,       32'h0,        5'd0,  0, ST_OK,    0));
    directed_rows.push_back(row(REQ_REMOVE_AT,  32'h0,        5'd0,  0, ST_OK,    0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    real_items = 0;
    while (real_items < RANDOM_ITEMS) begin
      s = random_row();
      if (s.req != REQ_SPARE_A && s.req != REQ_SPARE_B) real_items++;
      send_request(s);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    // Catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/plirs_pkg.sv
sv/plirs_ram.sv
sv/packed_list_insert_remove_search_core.sv
tb/sv/packed_list_insert_remove_search_core_tb.sv
